// ===== rtl/rmtc_pkg.sv =====
// Package for the relay auto/manual tap controller.
// Holds the channel numbering, register indexes, reset values and shared types.
// No dependencies.
package rmtc_pkg;

	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CH_FAN    = 0;
	localparam int unsigned CH_GARDEN = 1;
	localparam int unsigned CH_INDOOR = 2;

	localparam int unsigned IN_W    = 56;
	localparam int unsigned OUT_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W   = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_ON_TEMP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_OFF_TEMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP_MS = 3'd5;

	localparam logic [11:0] DARK_LEVEL_RST    = 12'd2500;
	localparam logic [11:0] BRIGHT_LEVEL_RST  = 12'd1500;
	localparam logic [7:0]  FAN_ON_TEMP_RST   = 8'd30;
	localparam logic [7:0]  FAN_OFF_TEMP_RST  = 8'd28;
	localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd100;
	localparam logic [15:0] DOUBLE_TAP_MS_RST = 16'd400;

	// Tap counter codes.
	localparam logic [1:0] TAPS_NONE   = 2'd0;
	localparam logic [1:0] TAPS_SINGLE = 2'd1;
	localparam logic [1:0] TAPS_DOUBLE = 2'd2;

	// Decision of the automatic rule for one channel.
	typedef struct packed {
		logic set_on;
		logic set_off;
	} auto_cmd_t;

	// Relay and mode of one channel after an item.
	typedef struct packed {
		logic relay_on;
		logic is_auto;
	} ch_state_t;

	typedef struct packed {
		logic [11:0] dark_level;
		logic [11:0] bright_level;
		logic [7:0]  fan_on_temp;
		logic [7:0]  fan_off_temp;
		logic [15:0] debounce_ms;
		logic [15:0] double_tap_ms;
	} cfg_t;

endpackage

// ===== rtl/rmtc_auto_rules.sv =====
// Automatic relay rules of the three channels: light hysteresis for the garden,
// light and presence for the indoor light, temperature hysteresis and presence for the fan.
// Depends on rmtc_pkg.
module rmtc_auto_rules
	import rmtc_pkg::*;
(
	input  cfg_t        cfg,
	input  logic [11:0] light_level,
	input  logic [7:0]  temperature,
	input  logic        presence,
	output auto_cmd_t   cmd [NUM_CH]
);

	logic is_dark;

	assign is_dark = light_level >= cfg.dark_level;

	always_comb begin
		cmd[CH_GARDEN].set_on  = is_dark;
		cmd[CH_GARDEN].set_off = light_level <= cfg.bright_level;
		// The indoor light's off request already holds at or below the dark threshold itself.
		cmd[CH_INDOOR].set_on  = is_dark && presence;
		cmd[CH_INDOOR].set_off = (light_level <= cfg.dark_level) || !presence;
		cmd[CH_FAN].set_on     = (temperature >= cfg.fan_on_temp) && presence;
		cmd[CH_FAN].set_off    = (temperature <= cfg.fan_off_temp) || !presence;
	end

endmodule

// ===== rtl/rmtc_channel.sv =====
// State of one relay channel: relay, mode, debounce and tap detection.
// Updates its registers when an item leaves the input register.
// Depends on rmtc_pkg.
module rmtc_channel
	import rmtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic [31:0] now_ms,
	input  logic        touch,
	input  auto_cmd_t   cmd,
	input  logic [15:0] debounce_ms,
	input  logic [15:0] double_tap_ms,
	output ch_state_t   nxt
);

	logic        on_q;
	logic        auto_q;
	logic        last_q;
	logic [31:0] deb_stamp_q;
	logic [31:0] tap_stamp_q;
	logic [1:0]  taps_q;

	logic        on_pre;
	logic [31:0] deb_diff;
	logic [31:0] tap_diff;
	logic        tap;
	logic [1:0]  taps_inc;
	logic [1:0]  taps_nxt;

	// The automatic rule is applied before the touch input is looked at.
	always_comb begin
		on_pre = on_q;
		if (auto_q) begin
			if (cmd.set_on) begin
				on_pre = 1'b1;
			end else if (cmd.set_off) begin
				on_pre = 1'b0;
			end
		end
	end

	assign deb_diff = now_ms - deb_stamp_q;
	assign tap_diff = now_ms - tap_stamp_q;
	assign tap      = (touch != last_q) && (deb_diff >= {16'd0, debounce_ms});
	assign taps_inc = (tap_diff <= {16'd0, double_tap_ms}) ? taps_q + 2'd1 : TAPS_SINGLE;

	always_comb begin
		nxt.relay_on = on_pre;
		nxt.is_auto  = auto_q;
		taps_nxt     = taps_q;
		if (tap) begin
			taps_nxt = taps_inc;
			if (taps_inc == TAPS_DOUBLE) begin
				nxt.is_auto = 1'b1;
				taps_nxt    = TAPS_NONE;
			end else if (taps_inc == TAPS_SINGLE) begin
				nxt.is_auto  = 1'b0;
				nxt.relay_on = !on_pre;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q        <= 1'b0;
			auto_q      <= 1'b1;
			last_q      <= 1'b1;
			deb_stamp_q <= '0;
			tap_stamp_q <= '0;
			taps_q      <= TAPS_NONE;
		end else if (upd) begin
			on_q   <= nxt.relay_on;
			auto_q <= nxt.is_auto;
			taps_q <= taps_nxt;
			if (tap) begin
				last_q      <= touch;
				deb_stamp_q <= now_ms;
				tap_stamp_q <= now_ms;
			end
		end
	end

endmodule

// ===== rtl/relay_auto_manual_tap_controller.sv =====
// Relay controller with automatic and touch-driven manual modes for fan,
// garden light and indoor light. An item passes through an input register and a
// result register; it leaves the input register only while the sink does not hold
// the previous result. One item per cycle while not so stalled; the channel state is
// read and written in the single stage between input and result registers.
// Reset (arst_n low): channels auto, relays off, configuration at defaults.
module relay_auto_manual_tap_controller
	import rmtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// now_ms[31:0], light_level[43:32], temperature[51:44], presence[52],
	// fan_touch[53], garden_touch[54], indoor_touch[55]
	input  logic [IN_W-1:0]      s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// fan_on[0], garden_on[1], indoor_on[2], fan_auto[3], garden_auto[4],
	// indoor_auto[5], zero[7:6]
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t            cfg_q;
	logic            valid_s1;
	logic [IN_W-1:0] data_s1;
	logic            out_valid_q;
	logic [5:0]      out_data_q;
	logic            adv;
	logic [NUM_CH-1:0] touch;
	auto_cmd_t       cmd [NUM_CH];
	ch_state_t       nxt [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_level    <= DARK_LEVEL_RST;
			cfg_q.bright_level  <= BRIGHT_LEVEL_RST;
			cfg_q.fan_on_temp   <= FAN_ON_TEMP_RST;
			cfg_q.fan_off_temp  <= FAN_OFF_TEMP_RST;
			cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
			cfg_q.double_tap_ms <= DOUBLE_TAP_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DARK_LEVEL:    cfg_q.dark_level    <= cfg_data[11:0];
				REG_BRIGHT_LEVEL:  cfg_q.bright_level  <= cfg_data[11:0];
				REG_FAN_ON_TEMP:   cfg_q.fan_on_temp   <= cfg_data[7:0];
				REG_FAN_OFF_TEMP:  cfg_q.fan_off_temp  <= cfg_data[7:0];
				REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data;
				REG_DOUBLE_TAP_MS: cfg_q.double_tap_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// An item leaves the input register when the result register is free or
	// being emptied in the same cycle.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	rmtc_auto_rules u_rules (
		.cfg         (cfg_q),
		.light_level (data_s1[43:32]),
		.temperature (data_s1[51:44]),
		.presence    (data_s1[52]),
		.cmd         (cmd)
	);

	assign touch = data_s1[55:53];

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		rmtc_channel u_ch (
			.clk           (clk),
			.arst_n        (arst_n),
			.upd           (adv),
			.now_ms        (data_s1[31:0]),
			.touch         (touch[i]),
			.cmd           (cmd[i]),
			.debounce_ms   (cfg_q.debounce_ms),
			.double_tap_ms (cfg_q.double_tap_ms),
			.nxt           (nxt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {nxt[CH_INDOOR].is_auto, nxt[CH_GARDEN].is_auto,
				nxt[CH_FAN].is_auto, nxt[CH_INDOOR].relay_on,
				nxt[CH_GARDEN].relay_on, nxt[CH_FAN].relay_on};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};

endmodule

// ===== rtl/rmtc_checker.sv =====
// Port-level checks of the relay auto/manual tap controller, bound to the top.
// Depends on rmtc_pkg.
module rmtc_checker
	import rmtc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [OUT_W-1:0]     m_axis_tdata
);

	// A result held back by the sink stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The input side only stalls while a finished result waits to be taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

	// Every accepted item passes the input register and then has a result showing.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("accepted item produced no result");

	// The padding bits of the result are zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
		else $error("result padding not zero");

endmodule

bind relay_auto_manual_tap_controller rmtc_checker u_rmtc_checker (.*);
